FILE: src/ptwa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page table walker with frame allocator.
package ptwa_pkg;

    localparam int DEF_OFFSET_BITS = 12;
    localparam int DEF_LEVEL_COUNT = 4;
    localparam int DEF_FRAME_COUNT = 64;

    localparam int VA_W = 48;
    localparam int PA_W = 18;
    localparam int ST_W = 2;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_ALLOC     = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNMAPPED = 2'd1,
        ST_NOFRAME  = 2'd2
    } pt_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_EVAL,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic       from_entry;
        logic       take;
        logic       write;
        logic       step;
        logic       finish;
        pt_status_t code;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic root_ok;
        logic entry_ok;
        logic avail;
        logic alloc;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: src/page_table_walker_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the page table walker with built-in bump frame allocator.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | opcode, virtual_address
//  out     | out_valid / out_stall| physical_address, status
//
// A request goes from acceptance through S_ROOT, then S_EVAL once per level,
// each level set by the dependent frame memory read, then S_DONE, which hands
// the result into the output register once it is free, then back to S_IDLE.
// After reset the frame memory is swept to zero, one entry per cycle, over all
// FRAME_COUNT * 2^(OFFSET_BITS-3) entries (32768 at defaults); in_stall stays
// high during the sweep. A stalled result is held while the next request walks.
module page_table_walker_allocator_top
    import ptwa_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int LEVEL_COUNT = DEF_LEVEL_COUNT,
    parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            opcode,
    input  logic [VA_W-1:0] virtual_address,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [PA_W-1:0] physical_address,
    output logic [ST_W-1:0] status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ptwa_ctrl #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_valid (in_valid),
        .in_stall (in_stall)
    );

    ptwa_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .LEVEL_COUNT (LEVEL_COUNT),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .opcode           (opcode),
        .virtual_address  (virtual_address),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .physical_address (physical_address),
        .status           (status)
    );

endmodule

FILE: src/ptwa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module ptwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/ptwa_dp.sv
`timescale 1ns / 1ps
// Datapath: frame memory, walk registers, bump allocator and result register.
module ptwa_dp
    import ptwa_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int LEVEL_COUNT = DEF_LEVEL_COUNT,
    parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dp_cmd_t         cmd,
    output dp_stat_t        stat,
    input  logic            opcode,
    input  logic [VA_W-1:0] virtual_address,
    input  logic            out_stall,
    output logic            out_valid,
    output logic [PA_W-1:0] physical_address,
    output logic [ST_W-1:0] status
);

    localparam int IDX_BITS = OFFSET_BITS - 3;
    localparam int FW       = $clog2(FRAME_COUNT);
    localparam int NF_W     = $clog2(FRAME_COUNT + 1);
    localparam int EW       = FW + 1;
    localparam int ADDR_W   = FW + IDX_BITS;
    localparam int DEPTH    = FRAME_COUNT * (2 ** IDX_BITS);
    localparam int WALK_W   = LEVEL_COUNT * IDX_BITS;
    localparam int VPN_W    = VA_W - OFFSET_BITS;

    localparam logic [NF_W-1:0]   FRAME_LIMIT = NF_W'(FRAME_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);

    logic [ADDR_W-1:0]      clear_cnt_reg, clear_cnt_next;
    logic [FW-1:0]          root_reg, root_next;
    logic [NF_W-1:0]        next_free_reg, next_free_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   alloc_reg, alloc_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [WALK_W-1:0]      walk_reg, walk_next;
    logic [FW-1:0]          table_reg, table_next;
    logic [ADDR_W-1:0]      rd_addr_reg, rd_addr_next;
    pt_status_t             res_status_reg, res_status_next;
    logic [PA_W-1:0]        out_pa_reg, out_pa_next;
    pt_status_t             out_status_reg, out_status_next;

    logic [WALK_W+VPN_W-1:0]        vpn_wide;
    logic [PA_W+FW+OFFSET_BITS-1:0] pa_wide;
    logic [FW-1:0]                  fresh;
    logic [FW-1:0]                  entry_frame;
    logic [FW-1:0]                  sel_frame;
    logic [ADDR_W-1:0]              rd_addr;
    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [EW-1:0]                  ram_wdata;
    logic [EW-1:0]                  ram_rdata;

    ptwa_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_frame_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        fresh       = next_free_reg[FW-1:0];
        entry_frame = ram_rdata[EW-1:1];

        stat.clear_last = (clear_cnt_reg == LAST_ADDR);
        stat.root_ok    = (root_reg != '0) && (NF_W'(root_reg) < FRAME_LIMIT);
        stat.entry_ok   = ram_rdata[0] && (entry_frame != '0)
                          && (NF_W'(entry_frame) < FRAME_LIMIT);
        stat.avail      = (next_free_reg < FRAME_LIMIT);
        stat.alloc      = (alloc_reg == OP_ALLOC);
        stat.out_free   = !out_valid_reg || !out_stall;

        if (cmd.take)
        begin
            sel_frame = fresh;
        end
        else if (cmd.from_entry)
        begin
            sel_frame = entry_frame;
        end
        else
        begin
            sel_frame = root_reg;
        end
        rd_addr = {sel_frame, walk_reg[WALK_W-1 -: IDX_BITS]};

        ram_we    = cmd.clear || cmd.write;
        ram_waddr = cmd.clear ? clear_cnt_reg : rd_addr_reg;
        ram_wdata = cmd.clear ? '0 : {fresh, 1'b1};

        vpn_wide = {{WALK_W{1'b0}}, virtual_address[VA_W-1:OFFSET_BITS]};
        pa_wide  = {{PA_W{1'b0}}, table_reg, offset_reg};
    end

    always_comb
    begin
        clear_cnt_next  = clear_cnt_reg;
        root_next       = root_reg;
        next_free_next  = next_free_reg;
        alloc_next      = alloc_reg;
        offset_next     = offset_reg;
        walk_next       = walk_reg;
        table_next      = table_reg;
        rd_addr_next    = rd_addr_reg;
        res_status_next = res_status_reg;
        out_pa_next     = out_pa_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.clear)
        begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
        end
        if (cmd.load)
        begin
            alloc_next  = opcode;
            offset_next = virtual_address[OFFSET_BITS-1:0];
            walk_next   = vpn_wide[WALK_W-1:0];
        end
        if (cmd.take)
        begin
            next_free_next = next_free_reg + 1'b1;
            if (!cmd.from_entry)
            begin
                root_next = fresh;
            end
        end
        if (cmd.step)
        begin
            walk_next    = walk_reg << IDX_BITS;
            table_next   = sel_frame;
            rd_addr_next = rd_addr;
        end
        if (cmd.finish)
        begin
            res_status_next = cmd.code;
        end
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_pa_next     = (res_status_reg == ST_OK) ? pa_wide[PA_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            root_reg      <= '0;
            next_free_reg <= NF_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clear_cnt_reg <= clear_cnt_next;
            root_reg      <= root_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alloc_reg      <= alloc_next;
        offset_reg     <= offset_next;
        walk_reg       <= walk_next;
        table_reg      <= table_next;
        rd_addr_reg    <= rd_addr_next;
        res_status_reg <= res_status_next;
        out_pa_reg     <= out_pa_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = out_pa_reg;
    assign status           = out_status_reg;

endmodule

FILE: src/ptwa_ctrl.sv
`timescale 1ns / 1ps
// Controller: memory clear sweep, walk sequencing and result hand-off.
module ptwa_ctrl
    import ptwa_pkg::*;
#(
    parameter int LEVEL_COUNT = DEF_LEVEL_COUNT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    input  logic     in_valid,
    output logic     in_stall
);

    localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVEL_COUNT - 1);

    ctrl_state_t       state_reg, state_next;
    logic [LVL_W-1:0]  level_reg, level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        in_stall   = 1'b1;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (stat.root_ok)
                begin
                    cmd.step = 1'b1;
                end
                else if (!stat.alloc)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_UNMAPPED;
                end
                else if (!stat.avail)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_NOFRAME;
                end
                else
                begin
                    cmd.take = 1'b1;
                    cmd.step = 1'b1;
                end
                level_next = '0;
                state_next = cmd.step ? S_EVAL : S_DONE;
            end
            S_EVAL:
            begin
                cmd.from_entry = 1'b1;
                if (stat.entry_ok)
                begin
                    cmd.step = 1'b1;
                end
                else if (!stat.alloc)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_UNMAPPED;
                end
                else if (!stat.avail)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_NOFRAME;
                end
                else
                begin
                    cmd.take  = 1'b1;
                    cmd.write = 1'b1;
                    cmd.step  = 1'b1;
                end
                if (cmd.step)
                begin
                    if (level_reg == LVL_LAST)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        level_next = level_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
